FILE: hdl/sact_pkg.sv
// Shared types and constants of the set-associative cache tag and replacement block.
// Used by the controller, datapath and top module of the block; depends on nothing.
package sact_pkg;

	localparam int SACT_TOTAL_LINES = 64;
	localparam int ADDR_W           = 32;
	localparam int TAG_W            = 32;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINES_LOG2 = 2'd3;

	// Organisation and policy codes
	localparam logic [1:0] MODE_DIRECT   = 2'd0;
	localparam logic [1:0] MODE_FOUR_WAY = 2'd1;
	localparam logic       POLICY_LRU    = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_VICT_RD,
		ST_VICT_CHK,
		ST_ROT_TEST,
		ST_ROT_RD,
		ST_ROT_CHK,
		ST_ROT_END,
		ST_DONE
	} sact_state_t;

	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic scan_step;
		logic fill;
		logic hit;
		logic vict_rd;
		logic vict_ld;
		logic rot_rd;
		logic rot_shift;
		logic rot_end;
		logic load_out;
	} sact_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic way_valid;
		logic way_match;
		logic last_way;
		logic rot_go;
		logic rot_go_next;
	} sact_status_t;

endpackage

FILE: hdl/sact_in_if.sv
// Input channel of the cache tag block: one byte address per word.
// Depends on nothing.
interface sact_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] access_address;

	modport source (output valid, output access_address, input ready);
	modport sink (input valid, input access_address, output ready);
endinterface

FILE: hdl/sact_out_if.sv
// Output channel of the cache tag block: hit, miss, eviction and victim tag per word.
// Depends on nothing.
interface sact_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic        miss;
	logic        evicted;
	logic [31:0] victim_tag;

	modport source (output valid, output hit, output miss, output evicted,
		output victim_tag, input ready);
	modport sink (input valid, input hit, input miss, input evicted,
		input victim_tag, output ready);
endinterface

FILE: hdl/sact_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module sact_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/sact_dpath.sv
// Datapath of the cache tag block: configuration, address split, tag, valid and
// FIFO pointer memories, scan and rotation counters, result registers.
// Depends on sact_pkg and sact_ram.
module sact_dpath import sact_pkg::*; #(
	parameter int TOTAL_LINES = SACT_TOTAL_LINES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [ADDR_W-1:0]     access_address,
	input  sact_cmd_t             cmd,
	output sact_status_t          status,
	output logic                  hit,
	output logic                  miss,
	output logic                  evicted,
	output logic [TAG_W-1:0]      victim_tag
);
	localparam int AW         = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
	localparam int LINES_LOG2 = $clog2(TOTAL_LINES + 1) - 1;
	localparam logic [2:0] LLOG_MAX = (LINES_LOG2 > 7) ? 3'd7 : 3'(LINES_LOG2);
	localparam logic [AW-1:0] LAST_LINE = AW'(TOTAL_LINES - 1);
	localparam logic [AW-1:0] ONE = AW'(1);

	logic [1:0] mode_q;
	logic       policy_q;
	logic [3:0] bbl_q;
	logic [2:0] cll_q;

	logic [3:0]        blog;
	logic [2:0]        lraw, llog, wlog, slog;
	logic [ADDR_W-1:0] block, set_full, base_full, wmask_full, tag_d;

	logic [TAG_W-1:0] tag_q;
	logic [AW-1:0]    set_q, base_q, wmask_q, i_q, k_q, clr_cnt_q;
	logic             lru_q;
	logic             hit_q, miss_q, evicted_q;
	logic [TAG_W-1:0] vtag_q;

	logic [AW-1:0]    victim, rd_addr, tag_waddr, valid_waddr, fifo_waddr, fifo_wdata;
	logic [AW-1:0]    fifo_rdata;
	logic [TAG_W-1:0] tag_rdata, tag_wdata;
	logic             valid_rdata, tag_we, valid_we, fifo_we;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DIRECT;
			policy_q <= 1'b0;
			bbl_q    <= 4'd4;
			cll_q    <= 3'd6;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_POLICY:     policy_q <= cfg_data[0];
				CFG_BLOCK_LOG2: bbl_q    <= cfg_data[3:0];
				CFG_LINES_LOG2: cll_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Split the address by the clamped geometry
	always_comb begin
		blog = (bbl_q > 4'd12) ? 4'd12 : bbl_q;
		lraw = (cll_q < 3'd2) ? 3'd2 : cll_q;
		llog = (lraw > LLOG_MAX) ? LLOG_MAX : lraw;
		case (mode_q)
			MODE_DIRECT:   wlog = 3'd0;
			MODE_FOUR_WAY: wlog = 3'd2;
			default:       wlog = llog;
		endcase
		slog       = llog - wlog;
		block      = access_address >> blog;
		set_full   = block & ((32'd1 << slog) - 32'd1);
		tag_d      = block >> slog;
		base_full  = set_full << wlog;
		wmask_full = (32'd1 << wlog) - 32'd1;
	end

	// Memory port steering
	always_comb begin
		victim = lru_q ? '0 : (fifo_rdata & wmask_q);
		if (cmd.vict_rd) begin
			rd_addr = base_q + victim;
		end else if (cmd.rot_rd) begin
			rd_addr = base_q + k_q + ONE;
		end else begin
			rd_addr = base_q + i_q;
		end
		tag_we      = cmd.fill | cmd.vict_ld | cmd.rot_shift | cmd.rot_end;
		tag_waddr   = cmd.fill ? (base_q + i_q) : (base_q + k_q);
		tag_wdata   = cmd.rot_shift ? tag_rdata : tag_q;
		valid_we    = cmd.clr_wr | cmd.fill;
		valid_waddr = cmd.clr_wr ? clr_cnt_q : (base_q + i_q);
		fifo_we     = cmd.clr_wr | (cmd.vict_rd & ~lru_q);
		fifo_waddr  = cmd.clr_wr ? clr_cnt_q : set_q;
		fifo_wdata  = cmd.clr_wr ? '0 : ((victim + ONE) & wmask_q);
	end

	sact_ram #(.WIDTH(TAG_W), .DEPTH(TOTAL_LINES)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(rd_addr), .rdata(tag_rdata)
	);

	sact_ram #(.WIDTH(1), .DEPTH(TOTAL_LINES)) u_valid_ram (
		.clk(clk), .we(valid_we), .waddr(valid_waddr), .wdata(~cmd.clr_wr),
		.raddr(rd_addr), .rdata(valid_rdata)
	);

	sact_ram #(.WIDTH(AW), .DEPTH(TOTAL_LINES)) u_fifo_ram (
		.clk(clk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
		.raddr(set_q), .rdata(fifo_rdata)
	);

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + ONE;
		end
	end

	// Working registers of the current word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tag_q     <= tag_d;
			set_q     <= set_full[AW-1:0];
			base_q    <= base_full[AW-1:0];
			wmask_q   <= wmask_full[AW-1:0];
			lru_q     <= (policy_q == POLICY_LRU);
			i_q       <= '0;
			k_q       <= '0;
			hit_q     <= 1'b0;
			miss_q    <= 1'b0;
			evicted_q <= 1'b0;
			vtag_q    <= '0;
		end
		if (cmd.scan_step) begin
			i_q <= i_q + ONE;
		end
		if (cmd.fill) begin
			k_q    <= i_q;
			miss_q <= 1'b1;
		end
		if (cmd.hit) begin
			k_q   <= i_q;
			hit_q <= 1'b1;
		end
		if (cmd.vict_rd) begin
			k_q <= victim;
		end
		if (cmd.vict_ld) begin
			vtag_q    <= tag_rdata;
			evicted_q <= 1'b1;
			miss_q    <= 1'b1;
		end
		if (cmd.rot_shift) begin
			k_q <= k_q + ONE;
		end
	end

	// Output register, held while the word waits
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit        <= hit_q;
			miss       <= miss_q;
			evicted    <= evicted_q;
			victim_tag <= vtag_q;
		end
	end

	// Status to the controller
	always_comb begin
		status.clr_last    = (clr_cnt_q == LAST_LINE);
		status.way_valid   = valid_rdata;
		status.way_match   = (tag_rdata == tag_q);
		status.last_way    = (i_q == wmask_q);
		status.rot_go      = lru_q && (k_q != wmask_q);
		status.rot_go_next = ((k_q + ONE) != wmask_q);
	end
endmodule

FILE: hdl/sact_ctrl.sv
// Controller of the cache tag block: clearing pass, way scan, replacement,
// LRU rotation and result handoff. Depends on sact_pkg.
module sact_ctrl import sact_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  sact_status_t status,
	output sact_cmd_t    cmd
);
	sact_state_t state_q, state_d;
	logic        out_valid_q;

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (!status.way_valid) begin
					cmd.fill = 1'b1;
					state_d  = ST_ROT_TEST;
				end else if (status.way_match) begin
					cmd.hit = 1'b1;
					state_d = ST_ROT_TEST;
				end else if (status.last_way) begin
					state_d = ST_VICT_RD;
				end else begin
					cmd.scan_step = 1'b1;
					state_d       = ST_SCAN_RD;
				end
			end
			ST_VICT_RD: begin
				cmd.vict_rd = 1'b1;
				state_d     = ST_VICT_CHK;
			end
			ST_VICT_CHK: begin
				cmd.vict_ld = 1'b1;
				state_d     = ST_ROT_TEST;
			end
			ST_ROT_TEST: begin
				state_d = status.rot_go ? ST_ROT_RD : ST_DONE;
			end
			ST_ROT_RD: begin
				cmd.rot_rd = 1'b1;
				state_d    = ST_ROT_CHK;
			end
			ST_ROT_CHK: begin
				if (status.way_valid) begin
					cmd.rot_shift = 1'b1;
					state_d       = status.rot_go_next ? ST_ROT_RD : ST_ROT_END;
				end else begin
					state_d = ST_ROT_END;
				end
			end
			ST_ROT_END: begin
				cmd.rot_end = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

FILE: hdl/set_assoc_cache_tag_replace.sv
// Tag and replacement engine of a set-associative cache: each address word returns one
// result word with hit, miss, eviction flag and victim tag. After reset a clearing pass
// over all TOTAL_LINES lines empties the valid bits and FIFO pointers before the first
// word is taken; configuration writes are taken at any time. A word of a set with W ways
// is accepted, then each way scanned is read and checked (tag and valid memories have a
// registered read), a replacement reads and loads the victim, rotation is tested, under
// LRU each line shifted is read and checked, a rotation probe may also find an empty way,
// the touched tag is placed, and the result is handed to the output register once that
// register is free. The next word is taken while the last result still waits to be read.
// Depends on sact_pkg, sact_in_if, sact_out_if, sact_ctrl and sact_dpath.
module set_assoc_cache_tag_replace import sact_pkg::*; #(
	parameter int TOTAL_LINES = SACT_TOTAL_LINES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sact_in_if.sink               access,
	sact_out_if.source            result
);
	sact_cmd_t    cmd;
	sact_status_t status;

	sact_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(access.valid), .in_ready(access.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.status(status), .cmd(cmd)
	);

	sact_dpath #(.TOTAL_LINES(TOTAL_LINES)) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.access_address(access.access_address),
		.cmd(cmd), .status(status),
		.hit(result.hit), .miss(result.miss), .evicted(result.evicted),
		.victim_tag(result.victim_tag)
	);

`ifndef SYNTHESIS
	// One word in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(access.valid && access.ready) |=> !access.ready)
		else $error("word accepted while previous word in progress");

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result.valid || result.ready))
		else $error("result overwritten before it was taken");

	// Exactly one of hit and miss per result
	a_hit_xor_miss: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.hit ^ result.miss))
		else $error("result is neither a single hit nor a single miss");

	// Victim tag is zero without eviction (the datapath sets miss with every eviction)
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.evicted) |-> (result.victim_tag == '0))
		else $error("victim tag set without eviction");
`endif
endmodule
